// ===== hdl/dnt_pkg.sv =====
// ----------------------------------------------------------------------------
// dnt_pkg
// Shared types and constants for the DNS name text to wire converter.
// ----------------------------------------------------------------------------
package dnt_pkg;

    localparam int MAX_RESULTS = 5;
    localparam int QUEUE_DEPTH = 4;

    localparam logic       REQ_CHAR = 1'b0;
    localparam logic       REQ_END  = 1'b1;

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_EMPTY_LABEL = 3'd1;
    localparam logic [2:0] ST_LABEL_LONG  = 3'd2;
    localparam logic [2:0] ST_NAME_LONG   = 3'd3;
    localparam logic [2:0] ST_TRAIL_BSL   = 3'd4;

    localparam logic       CFG_MAX_LABEL = 1'b0;
    localparam logic       CFG_MAX_NAME  = 1'b1;

    localparam logic [5:0] MAX_LABEL_RST = 6'd63;
    localparam logic [7:0] MAX_NAME_RST  = 8'd255;

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_BSL  = 2'd1;
    localparam logic [1:0] PH_ONE  = 2'd2;
    localparam logic [1:0] PH_TWO  = 2'd3;

    typedef struct packed {
        logic       req_type;
        logic [7:0] char_byte;
    } t_in_item;

    typedef struct packed {
        logic       is_done;
        logic [7:0] write_addr;
        logic [7:0] write_data;
        logic [2:0] status;
        logic [7:0] wire_length;
    } t_out_item;

    typedef struct packed {
        logic [2:0]                        cnt;
        t_out_item [MAX_RESULTS-1:0]       res;
    } t_cmd;

endpackage

// ===== hdl/dnt_front.sv =====
// ----------------------------------------------------------------------------
// dnt_front
// Accepts text items, tracks label and escape state, and turns each item
// into a group of up to five result items for the back end.
// ----------------------------------------------------------------------------
module dnt_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    input  dnt_pkg::t_in_item i_item,
    input  logic             i_q_full,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [7:0]       i_cfg_wdata,
    output logic             o_cmd_push,
    output dnt_pkg::t_cmd    o_cmd
);

    typedef struct packed {
        logic [8:0]    wp;
        logic [7:0]    ls;
        logic [1:0]    phase;
        logic [3:0]    d0;
        logic [3:0]    d1;
        logic          lead;
        logic          start;
        logic          err;
        logic          halted;
        dnt_pkg::t_cmd cmd;
    } t_work;

    logic [5:0] r_max_label;
    logic [7:0] r_max_name;
    logic [8:0] r_wp;
    logic [7:0] r_ls;
    logic [1:0] r_phase;
    logic [3:0] r_d0;
    logic [3:0] r_d1;
    logic       r_lead;
    logic       r_start;
    logic       r_err;
    t_work      n_work;
    logic       w_accept;

    function automatic t_work f_put(t_work w, logic done, logic [7:0] a, logic [7:0] b,
                                    logic [2:0] st, logic [7:0] len);
        t_work v;
        v = w;
        if (v.cmd.cnt < 3'(dnt_pkg::MAX_RESULTS)) begin
            v.cmd.res[v.cmd.cnt] = '{is_done: done, write_addr: a, write_data: b,
                                     status: st, wire_length: len};
            v.cmd.cnt = v.cmd.cnt + 3'd1;
        end
        return v;
    endfunction

    function automatic t_work f_fail(t_work w, logic [2:0] code);
        t_work v;
        v = f_put(w, 1'b1, 8'd0, 8'd0, code, 8'd0);
        v.err    = 1'b1;
        v.halted = 1'b1;
        return v;
    endfunction

    function automatic t_work f_emit(t_work w, logic [7:0] b, logic [7:0] mn);
        t_work v;
        v = w;
        if (v.halted) begin
            return v;
        end
        if (v.wp >= {1'b0, mn}) begin
            return f_fail(v, dnt_pkg::ST_NAME_LONG);
        end
        v = f_put(v, 1'b0, v.wp[7:0], b, dnt_pkg::ST_OK, 8'd0);
        v.wp = v.wp + 9'd1;
        return v;
    endfunction

    function automatic t_work f_close(t_work w, logic [5:0] ml, logic [7:0] mn);
        t_work      v;
        logic [8:0] len;
        v   = w;
        len = v.wp - {1'b0, v.ls} - 9'd1;
        if (v.halted) begin
            return v;
        end
        if (v.wp >= {1'b0, mn}) begin
            return f_fail(v, dnt_pkg::ST_NAME_LONG);
        end
        if (v.wp == {1'b0, v.ls} + 9'd1) begin
            return f_fail(v, dnt_pkg::ST_EMPTY_LABEL);
        end
        if (len > {3'b0, ml}) begin
            return f_fail(v, dnt_pkg::ST_LABEL_LONG);
        end
        v = f_put(v, 1'b0, v.ls, len[7:0], dnt_pkg::ST_OK, 8'd0);
        v.ls = v.wp[7:0];
        v.wp = v.wp + 9'd1;
        return v;
    endfunction

    function automatic t_work f_plain(t_work w, logic [7:0] c, logic [5:0] ml,
                                      logic [7:0] mn);
        t_work v;
        v = w;
        if (v.halted) begin
            return v;
        end
        if (c == dnt_pkg::CH_BSL) begin
            v.phase = dnt_pkg::PH_BSL;
        end else if (c == dnt_pkg::CH_DOT) begin
            v = f_close(v, ml, mn);
        end else begin
            v = f_emit(v, c, mn);
        end
        return v;
    endfunction

    function automatic t_work f_char(t_work w, logic [7:0] c, logic [5:0] ml,
                                     logic [7:0] mn);
        t_work      v;
        logic       dig;
        logic [9:0] val;
        v   = w;
        dig = (c >= dnt_pkg::CH_ZERO) && (c <= dnt_pkg::CH_NINE);
        val = 10'(v.d0) * 10'd100 + 10'(v.d1) * 10'd10 + 10'(c[3:0]);
        if (v.start) begin
            v.start = 1'b0;
            if (c == dnt_pkg::CH_DOT) begin
                v.lead = 1'b1;
                return v;
            end
        end else if (v.lead) begin
            v.lead = 1'b0;
            v = f_close(v, ml, mn);
            if (v.halted) begin
                return v;
            end
        end
        case (v.phase)
            dnt_pkg::PH_BSL: begin
                if (dig) begin
                    v.d0    = c[3:0];
                    v.phase = dnt_pkg::PH_ONE;
                end else begin
                    v.phase = dnt_pkg::PH_NONE;
                    v = f_emit(v, c, mn);
                end
            end
            dnt_pkg::PH_ONE: begin
                if (dig) begin
                    v.d1    = c[3:0];
                    v.phase = dnt_pkg::PH_TWO;
                end else begin
                    v.phase = dnt_pkg::PH_NONE;
                    v = f_emit(v, {4'h3, v.d0}, mn);
                    v = f_plain(v, c, ml, mn);
                end
            end
            dnt_pkg::PH_TWO: begin
                v.phase = dnt_pkg::PH_NONE;
                if (dig) begin
                    if (val <= 10'd255) begin
                        v = f_emit(v, val[7:0], mn);
                    end else begin
                        v = f_emit(v, {4'h3, v.d0}, mn);
                        v = f_emit(v, {4'h3, v.d1}, mn);
                        v = f_emit(v, c, mn);
                    end
                end else begin
                    v = f_emit(v, {4'h3, v.d0}, mn);
                    v = f_emit(v, {4'h3, v.d1}, mn);
                    v = f_plain(v, c, ml, mn);
                end
            end
            default: begin
                v.phase = dnt_pkg::PH_NONE;
                v = f_plain(v, c, ml, mn);
            end
        endcase
        return v;
    endfunction

    function automatic t_work f_end(t_work w, logic [5:0] ml, logic [7:0] mn);
        t_work      v;
        logic [8:0] len;
        v = w;
        if (v.lead) begin
            v = f_put(v, 1'b0, 8'd0, 8'd0, dnt_pkg::ST_OK, 8'd0);
            return f_put(v, 1'b1, 8'd0, 8'd0, dnt_pkg::ST_OK, 8'd1);
        end
        case (v.phase)
            dnt_pkg::PH_BSL: begin
                if (v.wp >= {1'b0, mn}) begin
                    return f_fail(v, dnt_pkg::ST_NAME_LONG);
                end
                return f_fail(v, dnt_pkg::ST_TRAIL_BSL);
            end
            dnt_pkg::PH_ONE: begin
                v = f_emit(v, {4'h3, v.d0}, mn);
            end
            dnt_pkg::PH_TWO: begin
                v = f_emit(v, {4'h3, v.d0}, mn);
                v = f_emit(v, {4'h3, v.d1}, mn);
            end
            default: begin
                v.phase = dnt_pkg::PH_NONE;
            end
        endcase
        if (v.halted) begin
            return v;
        end
        len = v.wp - {1'b0, v.ls} - 9'd1;
        if (v.wp != {1'b0, v.ls} + 9'd1) begin
            if (len > {3'b0, ml}) begin
                return f_fail(v, dnt_pkg::ST_LABEL_LONG);
            end
            v = f_put(v, 1'b0, v.ls, len[7:0], dnt_pkg::ST_OK, 8'd0);
            if (v.wp[8]) begin
                return f_fail(v, dnt_pkg::ST_NAME_LONG);
            end
            v.ls = v.wp[7:0];
        end
        if (v.ls >= mn) begin
            return f_fail(v, dnt_pkg::ST_NAME_LONG);
        end
        v = f_put(v, 1'b0, v.ls, 8'd0, dnt_pkg::ST_OK, 8'd0);
        return f_put(v, 1'b1, 8'd0, 8'd0, dnt_pkg::ST_OK, v.ls + 8'd1);
    endfunction

    assign w_accept = push && !i_q_full;

    always_comb begin
        n_work        = '0;
        n_work.wp     = r_wp;
        n_work.ls     = r_ls;
        n_work.phase  = r_phase;
        n_work.d0     = r_d0;
        n_work.d1     = r_d1;
        n_work.lead   = r_lead;
        n_work.start  = r_start;
        n_work.err    = r_err;
        if (i_item.req_type == dnt_pkg::REQ_END) begin
            if (!r_err) begin
                n_work = f_end(n_work, r_max_label, r_max_name);
            end
            n_work.wp    = 9'd1;
            n_work.ls    = 8'd0;
            n_work.phase = dnt_pkg::PH_NONE;
            n_work.d0    = 4'd0;
            n_work.d1    = 4'd0;
            n_work.lead  = 1'b0;
            n_work.start = 1'b1;
            n_work.err   = 1'b0;
        end else if (!r_err) begin
            n_work = f_char(n_work, i_item.char_byte, r_max_label, r_max_name);
        end
    end

    assign o_cmd      = n_work.cmd;
    assign o_cmd_push = w_accept && (n_work.cmd.cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_label <= dnt_pkg::MAX_LABEL_RST;
            r_max_name  <= dnt_pkg::MAX_NAME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dnt_pkg::CFG_MAX_LABEL: r_max_label <= i_cfg_wdata[5:0];
                dnt_pkg::CFG_MAX_NAME:  r_max_name  <= i_cfg_wdata;
                default: begin
                    r_max_label <= r_max_label;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 9'd1;
            r_ls    <= 8'd0;
            r_phase <= dnt_pkg::PH_NONE;
            r_d0    <= 4'd0;
            r_d1    <= 4'd0;
            r_lead  <= 1'b0;
            r_start <= 1'b1;
            r_err   <= 1'b0;
        end else if (w_accept) begin
            r_wp    <= n_work.wp;
            r_ls    <= n_work.ls;
            r_phase <= n_work.phase;
            r_d0    <= n_work.d0;
            r_d1    <= n_work.d1;
            r_lead  <= n_work.lead;
            r_start <= n_work.start;
            r_err   <= n_work.err;
        end
    end

endmodule

// ===== hdl/dnt_queue.sv =====
// ----------------------------------------------------------------------------
// dnt_queue
// Short first-in first-out queue of result groups between front and back.
// ----------------------------------------------------------------------------
module dnt_queue #(
    parameter int DEPTH = dnt_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dnt_pkg::t_cmd i_data,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output dnt_pkg::t_cmd o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dnt_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          w_do_push;
    logic          w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_head    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== hdl/dnt_back.sv =====
// ----------------------------------------------------------------------------
// dnt_back
// Walks through each queued result group and hands out one result item per
// cycle, while pop is held, from an output register.
// ----------------------------------------------------------------------------
module dnt_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dnt_pkg::t_cmd      i_head,
    input  logic               i_q_empty,
    input  logic               pop,
    output logic               o_q_pop,
    output logic               empty,
    output dnt_pkg::t_out_item o_res
);

    logic [2:0]         r_idx;
    logic               r_valid;
    dnt_pkg::t_out_item r_res;
    logic               w_load;
    logic               w_last;

    assign w_load  = !i_q_empty && (!r_valid || pop);
    assign w_last  = (r_idx + 3'd1) == i_head.cnt;
    assign o_q_pop = w_load && w_last;
    assign empty   = !r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= i_head.res[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_idx   <= w_last ? 3'd0 : r_idx + 3'd1;
                r_valid <= 1'b1;
            end else if (pop) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// ===== hdl/dns_name_text_to_wire.sv =====
// ----------------------------------------------------------------------------
// dns_name_text_to_wire
// A request accepted at a clock edge is written into the queue; its first result
// then moves from the queue head into the output register, where it can be popped.
// One request per cycle while the four-group queue has room; results leave at
// one per cycle while pop is held, so requests that make several results fill
// the queue and raise full until the back end catches up.
// Synchronous active-low reset clears name state, queue and output valid flag.
// ----------------------------------------------------------------------------
module dns_name_text_to_wire #(
    parameter int QUEUE_DEPTH = dnt_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  dnt_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output dnt_pkg::t_out_item o_res,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [7:0]         i_cfg_wdata
);

    logic          w_cmd_push;
    dnt_pkg::t_cmd w_cmd;
    logic          w_q_full;
    logic          w_q_empty;
    logic          w_q_pop;
    dnt_pkg::t_cmd w_q_head;

    assign full = w_q_full;

    dnt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .i_q_full    (w_q_full),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cmd_push  (w_cmd_push),
        .o_cmd       (w_cmd)
    );

    dnt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    dnt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (w_q_head),
        .i_q_empty (w_q_empty),
        .pop       (pop),
        .o_q_pop   (w_q_pop),
        .empty     (empty),
        .o_res     (o_res)
    );

    a_cmd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push |-> (w_cmd.cnt != 3'd0 && w_cmd.cnt <= 3'd5))
        else $error("Result group has an invalid count.");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_push |-> !w_q_full)
        else $error("Result group pushed into a full queue.");

    a_write_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_res.is_done) |->
        (o_res.status == dnt_pkg::ST_OK && o_res.wire_length == 8'd0))
        else $error("Buffer write carries status fields.");

    a_done_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_res.is_done) |->
        (o_res.write_addr == 8'd0 && o_res.write_data == 8'd0))
        else $error("Status item carries write fields.");

endmodule
